// ===== design/ppp_pkg.sv =====
// shared constants, types and codes for the perspective point projector
// no dependencies; every other design file imports this package
`default_nettype none

package ppp_pkg;

  // arithmetic format
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int COEF_W          = 32;
  localparam int COORD_W         = 32;
  localparam int OUT_W           = 32;
  localparam int SIZE_W          = 15;
  localparam int INDEX_W         = 5;
  localparam int STATUS_W        = 2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 15'd1920;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 15'd1080;

  // operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_VISIBLE = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_ZERO_W  = 2'd2,
    ST_GUARD   = 2'd3
  } status_t;

  // quotient magnitude of an ndc divide, with guard flag and sign
  typedef struct packed {
    logic                 over;
    logic                 neg;
    logic [FRAC_BITS:0]   mag;
  } ndc_q_t;

endpackage

`default_nettype wire

// ===== design/ppp_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on ppp_pkg for field widths
`default_nettype none

interface ppp_in_if import ppp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [INDEX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;

  modport source (output valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface ppp_out_if import ppp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [OUT_W-1:0]    screen_x;
  logic signed [OUT_W-1:0]    screen_y;

  modport source (output valid, status, screen_x, screen_y, input ready);
  modport sink (input valid, status, screen_x, screen_y, output ready);
endinterface

`default_nettype wire

// ===== design/perspective_point_projector.sv =====
// perspective point projector: view and projection matrix, ndc divide, viewport map
// items pass through registered stages to the result register; one item per cycle when not stalled
// the whole pipeline holds while a result waits on the output side
// reset clears coefficients to zero, valid bits, and sets screen size 1920x1080
// depends on ppp_pkg, ppp_if, ppp_mul_q and ppp_ndc_div
`default_nettype none

module perspective_point_projector import ppp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ppp_in_if.sink                     in_chan,
  ppp_out_if.source                  out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int W     = VALUE_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int ST_V  = 5;
  localparam int ST_P  = 10;
  localparam int ST_D  = ST_P + FB + 1;
  localparam int ST_G  = ST_D + 1;
  localparam int ST_O  = ST_G + 1;
  localparam int NST   = ST_O + 1;
  localparam int NDC_W = FB + 3;
  localparam int PW    = NDC_W + SIZE_W + 1;

  localparam logic [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [63:0] VMAX64 = 64'(VMAX);
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
  localparam logic signed [NDC_W-1:0] ONE_Q = NDC_W'(1) << FB;
  localparam logic [FB:0] GUARD_Q = (FB + 1)'(3) << (FB - 1);
  localparam logic signed [PW-1:0] O_MAX = PW'(32'h7FFF_FFFF);
  localparam logic signed [PW-1:0] O_MIN = -O_MAX - PW'(1);

  typedef struct packed {
    logic                      prj;
    logic [INDEX_W-1:0]        idx;
    logic [COEF_W-1:0]         val;
    logic                      behind;
    logic                      zero_w;
  } tag_t;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? VMIN : VMAX;
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] clamp_coef(input logic signed [COEF_W-1:0] c);
    logic signed [63:0] c64;
    c64 = 64'(c);
    if (c64 > VMAX64) begin
      clamp_coef = VMAX;
    end else if (c64 < VMIN64) begin
      clamp_coef = VMIN;
    end else begin
      clamp_coef = c64[W-1:0];
    end
  endfunction

  logic en;
  logic [NST-1:0] vld_r, vld_nxt;
  tag_t tag_r [NST];
  tag_t tag_nxt [NST];

  logic [SIZE_W-1:0] screen_width_r, screen_height_r;
  logic [COEF_W-1:0] vc_r [16];
  logic [COEF_W-1:0] pc_r [16];

  logic signed [COORD_W-1:0] pos_r [3];
  logic signed [W-1:0] vm [3][4];
  logic signed [W-1:0] bias1_r [4], bias2_r [4];
  logic signed [W-1:0] acc3_r [4], m1_3_r [4], m2_3_r [4];
  logic signed [W-1:0] acc4_r [4], m2_4_r [4];
  logic signed [W-1:0] v_r [4], v_nxt [4];
  logic signed [W-1:0] pm [4][3];
  logic signed [W-1:0] s8_r [3], m2_8_r [3], m3_8_r [3];
  logic signed [W-1:0] s9_r [3], m3_9_r [3];
  logic signed [W-1:0] pq_r [3], pq_nxt [3];
  ndc_q_t dx, dy;
  logic guard_r;
  logic signed [NDC_W-1:0] ax_r, ay_r;
  logic signed [NDC_W-1:0] nx, ny;
  logic signed [PW-1:0] sx_full, sy_full, sx_half, sy_half;
  status_t status_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic signed [OUT_W-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic cfg_wr;

  // pipeline advance: hold everything while a result is not taken
  assign en = !(vld_r[ST_O] && tag_r[ST_O].prj) || out_chan.ready;
  assign in_chan.ready = en;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[CFG_ADDR_W-1])
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_ADDR_W-1])
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(screen_width_r);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(screen_height_r);
      default:           prdata = '0;
    endcase
  end

  // tags and valid bits travel with the data
  always_comb begin
    vld_nxt[0]        = in_chan.valid;
    tag_nxt[0].prj    = (in_chan.operation == OP_PROJECT);
    tag_nxt[0].idx    = in_chan.coef_index;
    tag_nxt[0].val    = in_chan.coef_value;
    tag_nxt[0].behind = 1'b0;
    tag_nxt[0].zero_w = 1'b0;
    for (int i = 1; i < NST; i++) begin
      vld_nxt[i] = vld_r[i-1];
      tag_nxt[i] = tag_r[i-1];
    end
    tag_nxt[ST_V].behind = ~v_nxt[2][W-1];
    tag_nxt[ST_P].zero_w = (pq_nxt[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        tag_r[i] <= tag_nxt[i];
      end
      pos_r[0] <= in_chan.pos_x;
      pos_r[1] <= in_chan.pos_y;
      pos_r[2] <= in_chan.pos_z;
    end
  end

  // view matrix copy, updated as a load leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        vc_r[i] <= '0;
      end
    end else if (en && vld_r[0] && !tag_r[0].prj && !tag_r[0].idx[INDEX_W-1]) begin
      vc_r[tag_r[0].idx[INDEX_W-2:0]] <= tag_r[0].val;
    end
  end

  // projection matrix copy, updated as a load leaves the view stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        pc_r[i] <= '0;
      end
    end else if (en && vld_r[ST_V] && !tag_r[ST_V].prj && tag_r[ST_V].idx[INDEX_W-1]) begin
      pc_r[tag_r[ST_V].idx[INDEX_W-2:0]] <= tag_r[ST_V].val;
    end
  end

  // view products
  for (genvar r = 0; r < 3; r++) begin : g_vr
    for (genvar c = 0; c < 4; c++) begin : g_vc
      ppp_mul_q #(.AW(COORD_W), .W(W)) u_vmul (
        .clk (clk),
        .en  (en),
        .a   (pos_r[r]),
        .b   (vc_r[r*4+c]),
        .p   (vm[r][c])
      );
    end
  end

  // view accumulation, one saturating add per stage in row order
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      v_nxt[c] = sat_add(acc4_r[c], m2_4_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        bias1_r[c] <= clamp_coef(vc_r[12+c]);
        bias2_r[c] <= bias1_r[c];
        acc3_r[c]  <= sat_add(bias2_r[c], vm[0][c]);
        m1_3_r[c]  <= vm[1][c];
        m2_3_r[c]  <= vm[2][c];
        acc4_r[c]  <= sat_add(acc3_r[c], m1_3_r[c]);
        m2_4_r[c]  <= m2_3_r[c];
        v_r[c]     <= v_nxt[c];
      end
    end
  end

  // projection products for the x, y and w columns
  for (genvar r = 0; r < 4; r++) begin : g_pr
    for (genvar k = 0; k < 3; k++) begin : g_pk
      localparam int COL = (k == 2) ? 3 : k;
      ppp_mul_q #(.AW(W), .W(W)) u_pmul (
        .clk (clk),
        .en  (en),
        .a   (v_r[r]),
        .b   (pc_r[4'(r*4+COL)]),
        .p   (pm[r][k])
      );
    end
  end

  // projection accumulation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pq_nxt[k] = sat_add(s9_r[k], m3_9_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s8_r[k]   <= sat_add(pm[0][k], pm[1][k]);
        m2_8_r[k] <= pm[2][k];
        m3_8_r[k] <= pm[3][k];
        s9_r[k]   <= sat_add(s8_r[k], m2_8_r[k]);
        m3_9_r[k] <= m3_8_r[k];
        pq_r[k]   <= pq_nxt[k];
      end
    end
  end

  // ndc divides
  ppp_ndc_div #(.W(W)) u_div_x (
    .clk (clk),
    .en  (en),
    .n   (pq_r[0]),
    .d   (pq_r[2]),
    .res (dx)
  );

  ppp_ndc_div #(.W(W)) u_div_y (
    .clk (clk),
    .en  (en),
    .n   (pq_r[1]),
    .d   (pq_r[2]),
    .res (dy)
  );

  // guard band and viewport offsets
  assign nx = dx.neg ? -$signed(NDC_W'(dx.mag)) : $signed(NDC_W'(dx.mag));
  assign ny = dy.neg ? -$signed(NDC_W'(dy.mag)) : $signed(NDC_W'(dy.mag));

  always_ff @(posedge clk) begin
    if (en) begin
      guard_r <= dx.over || dy.over || (dx.mag > GUARD_Q) || (dy.mag > GUARD_Q);
      ax_r    <= ONE_Q + nx;
      ay_r    <= ONE_Q - ny;
    end
  end

  // viewport scale, floor halving, saturation to 32 bits
  always_comb begin
    sx_full = PW'(ax_r) * $signed(PW'({1'b0, screen_width_r}));
    sy_full = PW'(ay_r) * $signed(PW'({1'b0, screen_height_r}));
    sx_half = sx_full >>> 1;
    sy_half = sy_full >>> 1;
    if (tag_r[ST_G].behind) begin
      status_nxt = ST_BEHIND;
    end else if (tag_r[ST_G].zero_w) begin
      status_nxt = ST_ZERO_W;
    end else if (guard_r) begin
      status_nxt = ST_GUARD;
    end else begin
      status_nxt = ST_VISIBLE;
    end
    if (status_nxt != ST_VISIBLE) begin
      sx_nxt = '0;
      sy_nxt = '0;
    end else begin
      sx_nxt = (sx_half > O_MAX) ? 32'sh7FFF_FFFF :
               (sx_half < O_MIN) ? 32'sh8000_0000 : sx_half[OUT_W-1:0];
      sy_nxt = (sy_half > O_MAX) ? 32'sh7FFF_FFFF :
               (sy_half < O_MIN) ? 32'sh8000_0000 : sy_half[OUT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= status_nxt;
      sx_r         <= sx_nxt;
      sy_r         <= sy_nxt;
    end
  end

  assign out_chan.valid    = vld_r[ST_O] && tag_r[ST_O].prj;
  assign out_chan.status   = out_status_r;
  assign out_chan.screen_x = sx_r;
  assign out_chan.screen_y = sy_r;

endmodule

`default_nettype wire

// ===== design/ppp_mul_q.sv =====
// two-stage signed fixed point multiply: floor of product, saturated to W bits
// depends on ppp_pkg; the operand is split into two 32x32 partial products
`default_nettype none

module ppp_mul_q import ppp_pkg::*; #(
  parameter int AW = COORD_W,
  parameter int W  = VALUE_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [AW-1:0]     a,
  input  wire logic signed [COEF_W-1:0] b,
  output logic signed [W-1:0]           p
);

  localparam logic [80:0] MAXU = (81'(1) << (W - 1)) - 81'(1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};

  logic [AW-1:0]     a_mag;
  logic [COEF_W-1:0] b_mag;
  logic [63:0]       a_ext;
  logic [63:0]       lo_r, hi_r;
  logic              neg_r;
  logic [95:0]       full;
  logic [80:0]       q1;
  logic              rnd;
  logic [W-1:0]      p_nxt;

  // magnitudes and partial products
  assign a_mag = a[AW-1] ? (~a + 1'b1) : a;
  assign b_mag = b[COEF_W-1] ? (~b + 1'b1) : b;
  assign a_ext = 64'(a_mag);

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= 64'(a_ext[31:0]) * 64'(b_mag);
      hi_r  <= 64'(a_ext[63:32]) * 64'(b_mag);
      neg_r <= a[AW-1] ^ b[COEF_W-1];
    end
  end

  // combine, drop fraction bits with floor, saturate
  always_comb begin
    full = {hi_r, 32'b0} + {32'b0, lo_r};
    rnd  = neg_r & (|full[FRAC_BITS-1:0]);
    q1   = {1'b0, full[95:FRAC_BITS]} + 81'(rnd);
    if (neg_r) begin
      p_nxt = (q1 > MAXU) ? VMIN : (~q1[W-1:0] + 1'b1);
    end else begin
      p_nxt = (q1 > MAXU) ? VMAX : q1[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ppp_ndc_div.sv =====
// pipelined restoring divide giving |n|/|d| with FRAC_BITS fraction bits
// depends on ppp_pkg; one quotient bit per stage
`default_nettype none

module ppp_ndc_div import ppp_pkg::*; #(
  parameter int W = VALUE_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] n,
  input  wire logic signed [W-1:0] d,
  output ndc_q_t                   res
);

  localparam int FB = FRAC_BITS;

  logic [W-1:0]  mn, md;
  logic          ip;
  logic [W-1:0]  rem_r [FB+1];
  logic [W-1:0]  md_r  [FB+1];
  logic [FB:0]   q_r   [FB+1];
  logic          over_r[FB+1];
  logic          neg_r [FB+1];

  // integer part: a quotient of two or more fails the guard band anyway
  assign mn = n[W-1] ? (~n + 1'b1) : n;
  assign md = d[W-1] ? (~d + 1'b1) : d;
  assign ip = (mn >= md);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ip ? (mn - md) : mn;
      md_r[0]   <= md;
      q_r[0]    <= (FB + 1)'(ip);
      over_r[0] <= ({1'b0, mn} >= {md, 1'b0});
      neg_r[0]  <= n[W-1] ^ d[W-1];
    end
  end

  // fraction bits, one per stage
  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [W:0] t;
    logic       ge;
    logic [W:0] diff;

    assign t    = {rem_r[k-1], 1'b0};
    assign ge   = (t >= {1'b0, md_r[k-1]});
    assign diff = t - {1'b0, md_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[W-1:0] : t[W-1:0];
        md_r[k]   <= md_r[k-1];
        q_r[k]    <= {q_r[k-1][FB-1:0], ge};
        over_r[k] <= over_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end
    end
  end

  assign res.over = over_r[FB];
  assign res.neg  = neg_r[FB];
  assign res.mag  = q_r[FB];

endmodule

`default_nettype wire

// ===== dv/ppp_checker.sv =====
// result checker for the perspective point projector: watches both channels and the apb port,
// predicts each result in fixed point and compares it field by field
// depends on ppp_pkg and the channel interfaces in ppp_if
`default_nettype none

module ppp_checker import ppp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ppp_in_if                          in_chan,
  ppp_out_if                         out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         pending,
  output int                         checked
);

  localparam longint VMAX = (64'sd1 <<< (VALUE_WIDTH_DEF - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam longint GUARD_Q = 98304;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH  = CFG_ADDR_W'(4 * REG_SCREEN_WIDTH);
  localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT = CFG_ADDR_W'(4 * REG_SCREEN_HEIGHT);

  typedef struct {
    status_t            status;
    logic [OUT_W-1:0]   sx;
    logic [OUT_W-1:0]   sy;
  } proj_result_t;

  logic [COEF_W-1:0] coef_mem [32];
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  proj_result_t      projected_q[$];

  function automatic longint clamp_v(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // floor of the exact product, then saturate
  function automatic longint qmul(longint a, longint b);
    return clamp_v((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clamp_v(a + b);
  endfunction

  function automatic longint cf(int idx);
    return longint'($signed(coef_mem[idx]));
  endfunction

  // truncated quotient; zero when outside the guard band
  function automatic bit ndc_div(longint n, longint d, output longint q);
    longint mn, md, mq;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    mq = (mn <<< FRAC_BITS) / md;
    q = 0;
    if (mq > GUARD_Q) return 1'b0;
    q = ((n < 0) != (d < 0)) ? -mq : mq;
    return 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] to_screen(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[OUT_W-1:0];
  endfunction

  function automatic proj_result_t project_point(longint x, longint y, longint z);
    proj_result_t r;
    longint p[3];
    longint v[4];
    longint acc, px, py, pw, nx, ny;
    bit okx, oky;
    p[0] = x; p[1] = y; p[2] = z;
    r.status = ST_VISIBLE;
    r.sx = '0;
    r.sy = '0;
    // view transform, row vector with implicit w of one
    for (int c = 0; c < 4; c++) begin
      acc = cf(12 + c);
      for (int k = 0; k < 3; k++) acc = qadd(acc, qmul(p[k], cf(k * 4 + c)));
      v[c] = acc;
    end
    if (v[2] >= 0) begin
      r.status = ST_BEHIND;
      return r;
    end
    // projection x, y and w columns
    px = 0; py = 0; pw = 0;
    for (int k = 0; k < 4; k++) begin
      px = qadd(px, qmul(v[k], cf(16 + k * 4)));
      py = qadd(py, qmul(v[k], cf(16 + k * 4 + 1)));
      pw = qadd(pw, qmul(v[k], cf(16 + k * 4 + 3)));
    end
    if (pw == 0) begin
      r.status = ST_ZERO_W;
      return r;
    end
    okx = ndc_div(px, pw, nx);
    oky = ndc_div(py, pw, ny);
    if (!okx || !oky) begin
      r.status = ST_GUARD;
      return r;
    end
    // viewport map with y flipped
    r.sx = to_screen(((ONE_Q + nx) * longint'(width_q)) >>> 1);
    r.sy = to_screen(((ONE_Q - ny) * longint'(height_q)) >>> 1);
    return r;
  endfunction

  always @(posedge clk) begin
    proj_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) coef_mem[i] = '0;
      width_q = SCREEN_WIDTH_RST;
      height_q = SCREEN_HEIGHT_RST;
      projected_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_WIDTH) width_q = pwdata[SIZE_W-1:0];
        else if (paddr == ADDR_HEIGHT) height_q = pwdata[SIZE_W-1:0];
      end
      // result transaction against the oldest prediction
      if (out_chan.valid && out_chan.ready) begin
        checked++;
        if (projected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status=%0d x=%h y=%h",
                                         out_chan.status, out_chan.screen_x, out_chan.screen_y);
        end else begin
          e = projected_q.pop_front();
          if (out_chan.status !== e.status || out_chan.screen_x !== e.sx ||
              out_chan.screen_y !== e.sy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status=%0d x=%h y=%h, got status=%0d x=%h y=%h",
                       e.status, e.sx, e.sy, out_chan.status, out_chan.screen_x,
                       out_chan.screen_y);
          end
        end
      end
      // input transaction
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.operation == OP_LOAD) coef_mem[in_chan.coef_index] = in_chan.coef_value;
        else projected_q.push_back(project_point(longint'(in_chan.pos_x),
                                                 longint'(in_chan.pos_y),
                                                 longint'(in_chan.pos_z)));
      end
    end
    pending = projected_q.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench top for the perspective point projector: clock, reset, stimulus and verdict
// depends on ppp_pkg, ppp_if, the design and dv/ppp_checker
`default_nettype none

module tb;
  import ppp_pkg::*;

  localparam int ONE = 65536;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH  = CFG_ADDR_W'(4 * REG_SCREEN_WIDTH);
  localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT = CFG_ADDR_W'(4 * REG_SCREEN_HEIGHT);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  ppp_in_if  in_chan ();
  ppp_out_if out_chan ();

  int mismatches, pending, checked;
  int read_errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rcv_mode = 0, rcv_left = 0;

  always #5 clk = ~clk;

  perspective_point_projector dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ppp_checker chk (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  initial begin
    in_chan.valid = 1'b0;
    in_chan.operation = OP_LOAD;
    in_chan.coef_index = '0;
    in_chan.coef_value = '0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.pos_z = '0;
    out_chan.ready = 1'b0;
  end

  // receiver stall pattern: free running, light random, or long stalls
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode = $urandom_range(0, 2);
      rcv_left = $urandom_range(20, 200);
    end
    rcv_left--;
    case (rcv_mode)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= ($urandom_range(0, 9) < 7);
      default: out_chan.ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one input transaction, with bursts and gaps on the sender side
  task automatic send_item(input logic op, input int idx, input int cv,
                           input int x, input int y, input int z);
    in_chan.valid = 1'b1;
    in_chan.operation = op;
    in_chan.coef_index = idx[INDEX_W-1:0];
    in_chan.coef_value = cv;
    in_chan.pos_x = x;
    in_chan.pos_y = y;
    in_chan.pos_z = z;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_coef(input int idx, input int cv);
    send_item(OP_LOAD, idx, cv, $urandom, $urandom, $urandom);
  endtask

  task automatic project(input int x, input int y, input int z);
    send_item(OP_PROJECT, $urandom, $urandom, x, y, z);
  endtask

  // wait for every prediction to be met, then let any load drain
  task automatic wait_idle();
    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input int d);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = a; pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic cfg_check(input logic [CFG_ADDR_W-1:0] a, input int d);
    psel = 1'b1; pwrite = 1'b0; penable = 1'b0; paddr = a;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[SIZE_W-1:0] !== d[SIZE_W-1:0]) begin
      read_errors++;
      $display("register read at %0d: expected %0d, got %0d", a, d[SIZE_W-1:0],
               prdata[SIZE_W-1:0]);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // a plausible camera and perspective, or full random noise
  task automatic load_matrices();
    int kind;
    kind = $urandom_range(0, 7);
    for (int i = 0; i < 32; i++) begin
      int cv;
      if (kind == 0) begin
        cv = $urandom;
      end else if (i < 16) begin
        if (i == 15) cv = ONE;
        else if (i >= 12) cv = $urandom_range(0, 8 * ONE) - 4 * ONE;
        else if (i % 5 == 0) begin
          cv = $urandom_range(ONE / 2, 2 * ONE);
          if ($urandom_range(0, 5) == 0) cv = -cv;
        end else cv = $urandom_range(0, 8192) - 4096;
      end else begin
        if (i == 16 || i == 21) cv = $urandom_range(ONE / 2, 3 * ONE);
        else if (i == 27) cv = (kind == 1) ? 0 : -ONE;
        else cv = 0;
      end
      load_coef(i, cv);
    end
  endtask

  task automatic random_point();
    int r, zr, x, y, z;
    r = $urandom_range(0, 9);
    zr = $urandom_range(1, 300);
    if (r < 7) begin
      z = -(zr * ONE) - $urandom_range(0, ONE - 1);
      x = $urandom_range(0, 4 * zr * ONE) - 2 * zr * ONE;
      y = $urandom_range(0, 4 * zr * ONE) - 2 * zr * ONE;
    end else if (r == 7) begin
      z = $urandom_range(0, 400 * ONE);
      x = $urandom_range(0, 2 * ONE) - ONE;
      y = $urandom_range(0, 2 * ONE) - ONE;
    end else begin
      x = $urandom; y = $urandom; z = $urandom;
    end
    project(x, y, z);
  endtask

  initial begin
    int widths[6];
    int heights[6];
    widths  = '{1, 16384, 0, 32767, 640, 1};
    heights = '{16384, 1, 32767, 0, 480, 1};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    cfg_check(ADDR_WIDTH, SCREEN_WIDTH_RST);
    cfg_check(ADDR_HEIGHT, SCREEN_HEIGHT_RST);

    // directed: empty store, simple camera, guard band edge, zero w, extremes
    project(0, 0, -ONE);
    load_coef(0, ONE); load_coef(5, ONE); load_coef(10, ONE); load_coef(15, ONE);
    load_coef(16, ONE); load_coef(21, ONE); load_coef(27, -ONE);
    project(0, 0, -ONE);
    project(98304, 0, -ONE);
    project(98305, 0, -ONE);
    project(0, -98304, -ONE);
    project(0, 98305, -ONE);
    project(32'h7fffffff, 32'h7fffffff, 32'h80000000);
    project(0, 0, 0);
    project(0, 0, 1);
    load_coef(27, 0);
    project(0, 0, -ONE);
    load_coef(0, 32'h80000000);
    load_coef(31, 32'h7fffffff);
    project(32'h80000000, 32'h80000000, 32'h80000000);

    // random phases, each with its own screen size and matrices
    for (int ph = 0; ph < 10; ph++) begin
      int w, h;
      wait_idle();
      w = (ph < 6) ? widths[ph] : $urandom_range(1, 16384);
      h = (ph < 6) ? heights[ph] : $urandom_range(1, 16384);
      cfg_write(ADDR_WIDTH, w);
      cfg_write(ADDR_HEIGHT, h);
      cfg_check(ADDR_WIDTH, w);
      cfg_check(ADDR_HEIGHT, h);
      load_matrices();
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(0, 29) == 0) load_coef($urandom_range(0, 31), $urandom);
        else random_point();
      end
    end

    // drain
    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d input items over 10 screen sizes and matrix sets", items_sent);
    $display("checked %0d projected results, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && read_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
